@@ sv/fsw_pkg.sv @@
`default_nettype none

package fsw_pkg;

    // Field widths of the flash command interface.
    localparam int ADDR_W  = 15;
    localparam int WORD_W  = 14;
    localparam int DATA_W  = 8;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 8;

    // Address width of the job queue between the front and back parts.
    localparam int QUEUE_AW = 2;

    // Upper byte of every latched word (RETLW opcode) and the CRC-8 polynomial.
    localparam logic [5:0]        WORD_HIGH_BITS = 6'b110100;
    localparam logic [DATA_W-1:0] WORD_HIGH      = 8'h34;
    localparam logic [DATA_W-1:0] CRC_POLY       = 8'h07;

    // Flash command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_ERASE = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_FINAL = 2'd2
    } t_cmd;

    // One classified input item, passed from the front part to the back part.
    typedef struct packed {
        logic              first;   // record starts: erase the row first
        logic              commit;  // record ends: write the CRC word after the load
        logic [ADDR_W-1:0] addr;    // latch address of the payload word
        logic [DATA_W-1:0] data;    // payload byte
        logic [DATA_W-1:0] crc;     // CRC after this byte
    } t_job;

    // One flash command result.
    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_result;

    // CRC-8, MSB first, one byte.
    function automatic logic [DATA_W-1:0] crc8_byte(input logic [DATA_W-1:0] crc,
                                                    input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] x;
        x = crc ^ b;
        for (int k = 0; k < DATA_W; k++) begin
            if (x[DATA_W-1]) begin
                x = {x[DATA_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                x = {x[DATA_W-2:0], 1'b0};
            end
        end
        return x;
    endfunction

endpackage

`default_nettype wire

@@ sv/flash_settings_writer_crc8_top.sv @@
// An item's results pass through the job queue and then the output register.
// Each item gives one to three results (erase, load, final word).
// Input takes one item per cycle while the four-entry job queue has room.
// Output side drains one result per cycle from its output register while pop is held.
// Reset: synchronous, active low; clears record state, base address, queue and output valid.
`default_nettype none

module flash_settings_writer_crc8_top #(
    parameter int PAYLOAD_BYTES = 31
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [fsw_pkg::ADDR_W-1:0]  i_cfg_data,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [fsw_pkg::DATA_W-1:0]  i_data_byte,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [fsw_pkg::CMD_W-1:0]        o_command,
    output logic [fsw_pkg::ADDR_W-1:0]       o_flash_address,
    output logic [fsw_pkg::WORD_W-1:0]       o_flash_word,
    output logic                             o_last
);

    logic             accept;
    logic             q_empty;
    logic             q_pop;
    logic             res_valid;
    fsw_pkg::t_job    front_job;
    fsw_pkg::t_job    head_job;
    fsw_pkg::t_result res;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    // Front part: classify each item and track the record.
    fsw_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_job       (front_job)
    );

    // Job queue between the two parts.
    fsw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (accept),
        .i_wr_job (front_job),
        .o_full   (full),
        .o_empty  (q_empty),
        .i_rd     (q_pop),
        .o_rd_job (head_job)
    );

    // Back part: expand each job into flash commands.
    fsw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (head_job),
        .o_job_pop   (q_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop && res_valid)
    );

    assign empty           = !res_valid;
    assign o_command       = res.cmd;
    assign o_flash_address = res.addr;
    assign o_flash_word    = res.word;
    assign o_last          = res.last;

    // A pushed item is in the queue on the next cycle.
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !q_empty)
        else $error("queue empty after an accepted item");

    // The final word always ends the results of its item.
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_command == fsw_pkg::CMD_FINAL)) |-> o_last)
        else $error("final word without last");

    // An erase never ends an item and carries a zero word.
    a_erase_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_command == fsw_pkg::CMD_ERASE)) |-> (!o_last && (o_flash_word == '0)))
        else $error("malformed erase command");

    // The queue is never popped while empty.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job queue popped while empty");

endmodule

`default_nettype wire

@@ sv/fsw_front.sv @@
`default_nettype none

module fsw_front #(
    parameter int PAYLOAD_BYTES = 31
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [fsw_pkg::ADDR_W-1:0]  i_cfg_data,
    input  wire logic                        i_accept,
    input  wire logic [fsw_pkg::DATA_W-1:0]  i_data_byte,
    output fsw_pkg::t_job                    o_job
);

    localparam logic [fsw_pkg::COUNT_W:0] LAST_COUNT = (fsw_pkg::COUNT_W + 1)'(PAYLOAD_BYTES);

    logic [fsw_pkg::ADDR_W-1:0]  r_base;
    logic [fsw_pkg::ADDR_W-1:0]  r_addr;
    logic [fsw_pkg::DATA_W-1:0]  r_crc;
    logic [fsw_pkg::COUNT_W-1:0] r_count;

    logic                        first;
    logic                        commit;
    logic [fsw_pkg::ADDR_W-1:0]  cur_addr;
    logic [fsw_pkg::DATA_W-1:0]  crc_in;
    logic [fsw_pkg::DATA_W-1:0]  crc_new;
    logic [fsw_pkg::COUNT_W:0]   count_inc;

    // Classify the item: record start, record end, address and running CRC.
    always_comb begin
        first     = (r_count == '0);
        cur_addr  = first ? r_base : r_addr;
        crc_in    = first ? '0 : r_crc;
        crc_new   = fsw_pkg::crc8_byte(fsw_pkg::crc8_byte(crc_in, fsw_pkg::WORD_HIGH),
                                       i_data_byte);
        count_inc = {1'b0, r_count} + 1'b1;
        commit    = (count_inc >= LAST_COUNT);
    end

    assign o_job = '{first: first, commit: commit, addr: cur_addr,
                     data: i_data_byte, crc: crc_new};

    // Base address register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_data;
        end
    end

    // Record state: byte count, running CRC and next latch address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= '0;
            r_addr  <= '0;
        end else if (i_accept) begin
            if (commit) begin
                r_count <= '0;
                r_crc   <= '0;
                r_addr  <= r_base;
            end else begin
                r_count <= count_inc[fsw_pkg::COUNT_W-1:0];
                r_crc   <= crc_new;
                r_addr  <= cur_addr + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/fsw_queue.sv @@
`default_nettype none

module fsw_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_wr,
    input  wire fsw_pkg::t_job i_wr_job,
    output logic         o_full,
    output logic         o_empty,
    input  wire logic    i_rd,
    output fsw_pkg::t_job o_rd_job
);

    localparam int DEPTH = 1 << fsw_pkg::QUEUE_AW;

    fsw_pkg::t_job                 r_mem [DEPTH];
    logic [fsw_pkg::QUEUE_AW-1:0]  r_wr_ptr;
    logic [fsw_pkg::QUEUE_AW-1:0]  r_rd_ptr;
    logic [fsw_pkg::QUEUE_AW:0]    r_count;

    assign o_full   = (r_count == (fsw_pkg::QUEUE_AW + 1)'(DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_rd_job = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/fsw_back.sv @@
`default_nettype none

module fsw_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_job_valid,
    input  wire fsw_pkg::t_job i_job,
    output logic           o_job_pop,
    output logic           o_res_valid,
    output fsw_pkg::t_result o_res,
    input  wire logic      i_res_pop
);

    typedef enum logic [2:0] {
        PH_START  = 3'b001,
        PH_LOAD   = 3'b010,
        PH_COMMIT = 3'b100
    } t_phase;

    t_phase           r_phase;
    t_phase           n_phase;
    logic             r_res_valid;
    fsw_pkg::t_result r_res;
    fsw_pkg::t_result res;
    logic             done;
    logic             load_en;

    assign load_en = i_job_valid && (!r_res_valid || i_res_pop);

    // Pick the next command of the head job.
    always_comb begin
        res     = '0;
        n_phase = r_phase;
        done    = 1'b0;
        if ((r_phase == PH_START) && i_job.first) begin
            res.cmd  = fsw_pkg::CMD_ERASE;
            res.addr = i_job.addr;
            res.word = '0;
            res.last = 1'b0;
            n_phase  = PH_LOAD;
        end else if (r_phase == PH_COMMIT) begin
            res.cmd  = fsw_pkg::CMD_FINAL;
            res.addr = i_job.addr + 1'b1;
            res.word = {fsw_pkg::WORD_HIGH_BITS, i_job.crc};
            res.last = 1'b1;
            n_phase  = PH_START;
            done     = 1'b1;
        end else begin
            res.cmd  = fsw_pkg::CMD_LOAD;
            res.addr = i_job.addr;
            res.word = {fsw_pkg::WORD_HIGH_BITS, i_job.data};
            res.last = !i_job.commit;
            n_phase  = i_job.commit ? PH_COMMIT : PH_START;
            done     = !i_job.commit;
        end
    end

    assign o_job_pop   = load_en && done;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Phase within the head job and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_res_valid <= 1'b0;
        end else begin
            if (load_en) begin
                r_phase     <= n_phase;
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_res <= res;
        end
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD = 31;

    // Clock, reset and block ports.
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [fsw_pkg::ADDR_W-1:0]    i_cfg_data  = '0;
    logic                          push        = 1'b0;
    logic                          full;
    logic [fsw_pkg::DATA_W-1:0]    i_data_byte = '0;
    logic                          empty;
    logic                          pop         = 1'b0;
    logic [fsw_pkg::CMD_W-1:0]     o_command;
    logic [fsw_pkg::ADDR_W-1:0]    o_flash_address;
    logic [fsw_pkg::WORD_W-1:0]    o_flash_word;
    logic                          o_last;

    // Predicted record state and the flash commands still owed by the block.
    logic [fsw_pkg::ADDR_W-1:0]    base_addr = '0;
    logic [fsw_pkg::ADDR_W-1:0]    rec_addr  = '0;
    logic [fsw_pkg::DATA_W-1:0]    rec_crc   = '0;
    int                            rec_count = 0;
    fsw_pkg::t_result              pending_cmds[$];

    // Run statistics and handshake pacing controls.
    int mismatches   = 0;
    int items_taken  = 0;
    int cmds_checked = 0;
    int full_stalls  = 0;
    int base_writes  = 0;
    bit tx_idle_en   = 1'b0;
    bit rx_idle_en   = 1'b0;
    int rx_hold_req  = 0;
    int rx_left      = 0;

    flash_settings_writer_crc8_top #(
        .PAYLOAD_BYTES(PAYLOAD)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .empty          (empty),
        .pop            (pop),
        .o_command      (o_command),
        .o_flash_address(o_flash_address),
        .o_flash_word   (o_flash_word),
        .o_last         (o_last)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Bitwise CRC-8, polynomial 0x07, MSB first.
    function automatic logic [fsw_pkg::DATA_W-1:0] crc8_step(
        input logic [fsw_pkg::DATA_W-1:0] c,
        input logic [fsw_pkg::DATA_W-1:0] b);
        logic fb;
        for (int i = fsw_pkg::DATA_W - 1; i >= 0; i--) begin
            fb = c[fsw_pkg::DATA_W-1] ^ b[i];
            c  = {c[fsw_pkg::DATA_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ fsw_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic fsw_pkg::t_result make_cmd(input fsw_pkg::t_cmd c,
                                                  input logic [fsw_pkg::ADDR_W-1:0] a,
                                                  input logic [fsw_pkg::WORD_W-1:0] w);
        fsw_pkg::t_result r;
        r.cmd  = c;
        r.addr = a;
        r.word = w;
        r.last = 1'b0;
        return r;
    endfunction

    // Work out the flash commands that one payload byte causes.
    function automatic void predict_commands(input logic [fsw_pkg::DATA_W-1:0] b);
        fsw_pkg::t_result cmds[3];
        int               n;
        n = 0;
        // A record's first byte latches the base and erases the row.
        if (rec_count == 0) begin
            rec_addr  = base_addr;
            rec_crc   = '0;
            cmds[n++] = make_cmd(fsw_pkg::CMD_ERASE, rec_addr, '0);
        end
        cmds[n++] = make_cmd(fsw_pkg::CMD_LOAD, rec_addr, {fsw_pkg::WORD_HIGH_BITS, b});
        rec_crc   = crc8_step(crc8_step(rec_crc, fsw_pkg::WORD_HIGH), b);
        rec_addr  = rec_addr + 1'b1;
        rec_count = rec_count + 1;
        // The record's last byte is followed by the CRC word at base + payload length.
        if (rec_count >= PAYLOAD) begin
            cmds[n++] = make_cmd(fsw_pkg::CMD_FINAL, rec_addr,
                                 {fsw_pkg::WORD_HIGH_BITS, rec_crc});
            rec_count = 0;
            rec_crc   = '0;
            rec_addr  = base_addr;
        end
        cmds[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) begin
            pending_cmds.push_back(cmds[i]);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what,
                 got, want);
        mismatches++;
    endtask

    // Monitor: tracks register writes and accepted items, and checks each result.
    always @(posedge i_clk) begin : monitor
        fsw_pkg::t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                base_addr = i_cfg_data;
            end
            if (push && full) begin
                full_stalls++;
            end
            if (push && !full) begin
                predict_commands(i_data_byte);
                items_taken++;
            end
            if (pop && !empty) begin
                if (pending_cmds.size() == 0) begin
                    report_mismatch("result with none pending", o_command, 0);
                end else begin
                    want = pending_cmds.pop_front();
                    if (o_command !== want.cmd) begin
                        report_mismatch("command", o_command, want.cmd);
                    end
                    if (o_flash_address !== want.addr) begin
                        report_mismatch("flash_address", o_flash_address, want.addr);
                    end
                    if (o_flash_word !== want.word) begin
                        report_mismatch("flash_word", o_flash_word, want.word);
                    end
                    if (o_last !== want.last) begin
                        report_mismatch("last", o_last, want.last);
                    end
                    cmds_checked++;
                end
            end
        end
    end

    // Receiver: pops results, with random stall bursts and requested long holds.
    always @(negedge i_clk) begin : receiver
        if (rx_hold_req > 0) begin
            rx_left     = rx_hold_req;
            rx_hold_req = 0;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (rx_left > 0) begin
            pop <= 1'b0;
            rx_left--;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            rx_left = $urandom_range(0, 7);
        end else begin
            pop <= 1'b1;
        end
    end

    // Offer one payload byte, possibly after an idle burst, and wait until it is taken.
    task automatic send_byte(input logic [fsw_pkg::DATA_W-1:0] b);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (full);
    endtask

    // Stop offering items until every predicted command has come out.
    task automatic wait_all_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [fsw_pkg::ADDR_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        base_writes++;
    endtask

    // First record starts at the reset base with extreme and alternating bytes.
    task automatic test_reset_base_record();
        logic [fsw_pkg::DATA_W-1:0] pattern[6] = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h55, 8'haa};
        foreach (pattern[i]) begin
            send_byte(pattern[i]);
        end
        wait_all_results();
    endtask

    // A base written mid-record must not move the running record; the record
    // then ends with its CRC word right after the last payload word.
    task automatic test_base_change_mid_record();
        write_base(15'h7ff8);
        repeat (PAYLOAD - 6) send_byte($urandom_range(0, 255));
        wait_all_results();
    endtask

    // Receiver holds off for a long stretch so the block fills and stalls its input.
    task automatic test_full_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        @(negedge i_clk);
        rx_hold_req = 60;
        repeat (20) send_byte($urandom_range(0, 255));
        wait_all_results();
    endtask

    // Random records across several base settings; the first phase keeps the
    // high base from before, so its records wrap around the address space.
    task automatic test_random_records();
        logic [fsw_pkg::ADDR_W-1:0] next_base;
        for (int p = 0; p < 8; p++) begin
            if (p > 0) begin
                wait_all_results();
                case (p)
                    1: next_base = 15'h7fff;
                    2: next_base = 15'h0000;
                    3: next_base = 15'h2aaa;
                    4: next_base = 15'h5555;
                    default: next_base = $urandom_range(0, 32767);
                endcase
                write_base(next_base);
            end
            tx_idle_en = (p % 3 != 1);
            rx_idle_en = (p % 3 != 2);
            repeat ($urandom_range(30, 60)) send_byte($urandom_range(0, 255));
        end
        wait_all_results();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_unthrottled_stream();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (60) send_byte($urandom_range(0, 255));
        wait_all_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_base_record();
        test_base_change_mid_record();
        test_full_backpressure();
        test_random_records();
        test_unthrottled_stream();

        $display("Sent %0d payload bytes and checked %0d flash commands over %0d base writes.",
                 items_taken, cmds_checked, base_writes);
        $display("Input was held off by a full block for %0d cycles; %0d mismatches.",
                 full_stalls, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
